// ===== rtl/afr_pkg.sv =====
// ----------------------------------------------------------------------------
// afr_pkg: shared types and constants of the frame responder
// Verdict codes, configuration register indexes and reset values, the
// configuration bundle and the descriptor that passes from front to back.
// ----------------------------------------------------------------------------
package afr_pkg;

    // verdict codes on the result channel
    localparam logic [1:0] VERD_DROP  = 2'd0;
    localparam logic [1:0] VERD_XMIT  = 2'd1;
    localparam logic [1:0] VERD_ABORT = 2'd2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ETHERTYPE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_TAG    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POSINT_TAG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTETS_TAG   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_TAG     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_ZERO   = 3'd6;

    // register values after reset
    localparam logic [15:0] RST_ETHERTYPE    = 16'hda1e;
    localparam logic [15:0] RST_PACKET_LIMIT = 16'd13;
    localparam logic [7:0]  RST_ARRAY_TAG    = 8'd6;
    localparam logic [7:0]  RST_POSINT_TAG   = 8'd16;
    localparam logic [7:0]  RST_OCTETS_TAG   = 8'd8;
    localparam logic [7:0]  RST_NULL_TAG     = 8'd0;
    localparam logic [7:0]  RST_SMALL_ZERO   = 8'd128;

    typedef struct packed {
        logic [15:0] ethertype;
        logic [15:0] packet_limit;
        logic [7:0]  array_tag;
        logic [7:0]  posint_tag;
        logic [7:0]  octets_tag;
        logic [7:0]  null_tag;
        logic [7:0]  small_zero;
    } t_cfg;

    // one received frame, waiting in the queue for the back end
    typedef struct packed {
        logic        bank;         // frame memory bank holding the bytes
        logic        short_frame;  // length below the minimum frame
        logic        have_out;     // outbound word present and not all ones
        logic [63:0] outb;         // outbound word
    } t_frame_desc;

endpackage

// ===== rtl/afr_frame_ram.sv =====
// ----------------------------------------------------------------------------
// afr_frame_ram: frame byte memory
// One write port and one read port with registered read data. The read
// data register holds its value while no read is issued.
// ----------------------------------------------------------------------------
module afr_frame_ram #(
    parameter int AW = 7
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [2**AW];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== rtl/afr_front.sv =====
// ----------------------------------------------------------------------------
// afr_front: receive side of the frame responder
// Accepts frame bytes into the current memory bank, counts the length and
// on the last byte hands a descriptor to the queue and flips banks.
// ----------------------------------------------------------------------------
module afr_front #(
    parameter  int FRAME_BYTES = 64,
    parameter  int MIN_FRAME   = 60,
    localparam int PW          = $clog2(FRAME_BYTES),
    localparam int AW          = PW + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_frame_byte,
    input  logic                 i_frame_last,
    input  logic                 i_outbound_present,
    input  logic [63:0]          i_outbound_value,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output afr_pkg::t_frame_desc o_q_desc,
    output logic                 o_wr_en,
    output logic [AW-1:0]        o_wr_addr,
    output logic [7:0]           o_wr_data
);

    import afr_pkg::*;

    localparam int              POSW    = $clog2(FRAME_BYTES + 1);
    localparam logic [POSW-1:0] POS_END = POSW'(FRAME_BYTES);
    localparam logic [POSW:0]   LEN_MIN = (POSW + 1)'(MIN_FRAME);

    logic [POSW-1:0] r_pos, n_pos;
    logic            r_bank, n_bank;
    logic [POSW-1:0] len_now;
    logic            accept;
    logic            in_range;

    // a free bank exists whenever the queue has room
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign in_range   = r_pos < POS_END;
    assign len_now    = in_range ? r_pos + 1'b1 : r_pos;

    // bytes past the bank size are dropped
    assign o_wr_en   = accept && in_range;
    assign o_wr_addr = {r_bank, r_pos[PW-1:0]};
    assign o_wr_data = i_frame_byte;

    // descriptor on the last beat
    assign o_q_push = accept && i_frame_last;
    always_comb begin
        o_q_desc.bank        = r_bank;
        o_q_desc.short_frame = {1'b0, len_now} < LEN_MIN;
        o_q_desc.have_out    = i_outbound_present && (i_outbound_value != '1);
        o_q_desc.outb        = i_outbound_value;
    end

    // position and bank
    always_comb begin
        n_pos  = r_pos;
        n_bank = r_bank;
        if (accept) begin
            if (i_frame_last) begin
                n_pos  = '0;
                n_bank = !r_bank;
            end else begin
                n_pos = len_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_bank <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_bank <= n_bank;
        end
    end

endmodule

// ===== rtl/afr_desc_queue.sv =====
// ----------------------------------------------------------------------------
// afr_desc_queue: two-entry descriptor queue
// One entry per frame memory bank; an entry stays until the back end has
// loaded the last beat of its frame into its output register.
// ----------------------------------------------------------------------------
module afr_desc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  afr_pkg::t_frame_desc i_desc,
    input  logic                 i_pop,
    output afr_pkg::t_frame_desc o_head,
    output logic                 o_full,
    output logic                 o_empty
);

    import afr_pkg::*;

    localparam logic [1:0] Q_DEPTH = 2'd2;

    t_frame_desc r_mem [2];
    logic        r_wp, n_wp;
    logic        r_rp, n_rp;
    logic [1:0]  r_cnt, n_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_full  = r_cnt == Q_DEPTH;
    assign o_empty = r_cnt == 2'd0;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    // pointers and fill count
    always_comb begin
        n_wp  = i_push ? !r_wp : r_wp;
        n_rp  = i_pop  ? !r_rp : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/afr_back.sv =====
// ----------------------------------------------------------------------------
// afr_back: handshake step and transmit side of the frame responder
// Reads the header bytes of the queued frame, runs one handshake step,
// keeps the message counter and streams the rewritten frame or a single
// drop/abort beat through the output register.
// ----------------------------------------------------------------------------
module afr_back #(
    parameter  int FRAME_BYTES = 64,
    parameter  int MIN_FRAME   = 60,
    localparam int PW          = $clog2(FRAME_BYTES),
    localparam int AW          = PW + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  afr_pkg::t_cfg        i_cfg,
    input  logic                 i_q_empty,
    input  afr_pkg::t_frame_desc i_q_head,
    output logic                 o_q_pop,
    output logic                 o_rd_en,
    output logic [AW-1:0]        o_rd_addr,
    input  logic [7:0]           i_rd_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_last,
    output logic [1:0]           o_verdict,
    output logic                 o_outbound_taken
);

    import afr_pkg::*;

    localparam int KW = $clog2(MIN_FRAME);

    // byte offsets within the frame
    localparam logic [KW-1:0] K_LAST     = KW'(MIN_FRAME - 1);
    localparam logic [KW-1:0] K_MAC      = KW'(6);
    localparam logic [KW-1:0] K_HDR_LO   = KW'(12);
    localparam logic [KW-1:0] K_LEN      = KW'(15);
    localparam logic [KW-1:0] K_STATE    = KW'(16);
    localparam logic [KW-1:0] K_OTHER    = KW'(17);
    localparam logic [KW-1:0] K_CNT_LSB  = KW'(20);
    localparam logic [KW-1:0] K_CNT_MSB  = KW'(21);
    localparam logic [KW-1:0] K_BLOB     = KW'(22);
    localparam logic [KW-1:0] K_BLOB_LEN = KW'(23);
    localparam logic [KW-1:0] K_WORD_I   = KW'(24);
    localparam logic [KW-1:0] K_WORD_U   = KW'(32);
    localparam logic [KW-1:0] K_MSG_END  = KW'(40);
    localparam logic [KW-1:0] K_WORD_SZ  = KW'(8);

    // back end states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_HDR    = 3'd1;
    localparam logic [2:0] ST_WAIT   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_VERD   = 3'd5;

    // sources of the two transfer words
    localparam logic [1:0] WI_ONES  = 2'd0;
    localparam logic [1:0] WI_OUTB  = 2'd1;
    localparam logic [1:0] WI_STORE = 2'd2;
    localparam logic       WU_ONES  = 1'b0;
    localparam logic       WU_STORE = 1'b1;

    logic [2:0]    r_state, n_state;
    logic [KW-1:0] r_k, n_k;
    logic [KW-1:0] r_rd_k, n_rd_k;
    logic          r_rd_vld, n_rd_vld;
    logic          r_iss_done, n_iss_done;
    logic [15:0]   r_msg_cnt, n_msg_cnt;
    logic [1:0]    r_verdict, n_verdict;
    logic          r_taken, n_taken;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_hdr [12];
    logic [3:0]    hdr_idx;

    // header fields
    logic [15:0] h_type, h_n;
    logic [7:0]  h_msg, h_len, h_state, h_other, h_cnt, h_cnt_len, h_blob, h_blob_len;

    // small integer codes
    logic [7:0] sm_0, sm_1, sm_2, sm_3, sm_4, sm_5, sm_6, sm_16, sm_24;

    // step result
    logic        hdr_good;
    logic        d_ok, d_taken, d_reload, d_abort;
    logic [7:0]  d_other, d_len, d_blob, d_blob_len;
    logic [1:0]  d_wi;
    logic        d_wu;
    logic [15:0] d_base, d_cnt;

    // streaming
    logic          slot_free, s2_adv, issue;
    logic          load_emit, load_verd;
    logic [KW-1:0] rd_ofs;
    logic [2:0]    word_byte;
    logic [7:0]    ov_byte, emit_byte;

    // MACs and transfer words trade places on the way out
    function automatic logic [KW-1:0] src_ofs(input logic [KW-1:0] k);
        if (k < K_MAC) begin
            return k + K_MAC;
        end else if (k < K_HDR_LO) begin
            return k - K_MAC;
        end else if (k >= K_WORD_I && k < K_WORD_U) begin
            return k + K_WORD_SZ;
        end else if (k >= K_WORD_U && k < K_MSG_END) begin
            return k - K_WORD_SZ;
        end else begin
            return k;
        end
    endfunction

    assign h_type     = {r_hdr[0], r_hdr[1]};
    assign h_msg      = r_hdr[2];
    assign h_len      = r_hdr[3];
    assign h_state    = r_hdr[4];
    assign h_other    = r_hdr[5];
    assign h_cnt      = r_hdr[6];
    assign h_cnt_len  = r_hdr[7];
    assign h_n        = {r_hdr[9], r_hdr[8]};
    assign h_blob     = r_hdr[10];
    assign h_blob_len = r_hdr[11];

    assign sm_0  = i_cfg.small_zero;
    assign sm_1  = i_cfg.small_zero + 8'd1;
    assign sm_2  = i_cfg.small_zero + 8'd2;
    assign sm_3  = i_cfg.small_zero + 8'd3;
    assign sm_4  = i_cfg.small_zero + 8'd4;
    assign sm_5  = i_cfg.small_zero + 8'd5;
    assign sm_6  = i_cfg.small_zero + 8'd6;
    assign sm_16 = i_cfg.small_zero + 8'd16;
    assign sm_24 = i_cfg.small_zero + 8'd24;

    assign hdr_good = (h_type == i_cfg.ethertype) && (h_msg == i_cfg.array_tag)
                   && (h_cnt == i_cfg.posint_tag) && (h_cnt_len == sm_2);

    // one handshake step; header registers hold still through the emit pass
    always_comb begin
        d_ok       = 1'b1;
        d_other    = h_other;
        d_len      = h_len;
        d_blob     = h_blob;
        d_blob_len = h_blob_len;
        d_wi       = WI_ONES;
        d_wu       = WU_ONES;
        d_taken    = 1'b0;
        d_reload   = 1'b0;
        priority if (!hdr_good) begin
            d_ok = 1'b0;
        end else if (h_len == sm_6) begin
            priority if (h_other == sm_0) begin
                d_other    = sm_1;
                d_len      = sm_6;
                d_blob     = i_cfg.null_tag;
                d_blob_len = i_cfg.null_tag;
            end else if (h_other == sm_1) begin
                d_other = sm_2;
                if (h_other < h_state) begin
                    if (i_q_head.have_out) begin
                        d_wi       = WI_OUTB;
                        d_other    = sm_3;
                        d_len      = sm_24;
                        d_blob     = i_cfg.octets_tag;
                        d_blob_len = sm_16;
                    end
                end else begin
                    d_reload = 1'b1;
                end
            end else if (h_other == sm_2) begin
                d_other = sm_1;
                if (h_other > h_state && i_q_head.have_out) begin
                    d_wi       = WI_OUTB;
                    d_other    = sm_3;
                    d_len      = sm_24;
                    d_blob     = i_cfg.octets_tag;
                    d_blob_len = sm_16;
                end
            end else begin
                d_ok = 1'b0;
            end
        end else if (h_len == sm_24 && h_blob == i_cfg.octets_tag && h_blob_len == sm_16) begin
            d_wu = WU_STORE;
            priority if (h_other == sm_3) begin
                if (h_other < h_state) begin
                    d_other    = sm_2;
                    d_len      = sm_6;
                    d_blob     = i_cfg.null_tag;
                    d_blob_len = i_cfg.null_tag;
                end else begin
                    d_other    = sm_4;
                    d_len      = sm_24;
                    d_blob     = i_cfg.octets_tag;
                    d_blob_len = sm_16;
                end
            end else if (h_other == sm_4) begin
                d_wi       = WI_STORE;
                d_other    = (h_other < h_state) ? sm_3 : sm_5;
                d_len      = sm_24;
                d_blob     = i_cfg.octets_tag;
                d_blob_len = sm_16;
            end else if (h_other == sm_5) begin
                d_other    = sm_6;
                d_len      = sm_24;
                d_blob     = i_cfg.octets_tag;
                d_blob_len = sm_16;
            end else if (h_other == sm_6) begin
                // proceed: outbound word consumed, both words cleared
                d_taken    = 1'b1;
                d_wu       = WU_ONES;
                d_other    = sm_1;
                d_len      = sm_6;
                d_blob     = i_cfg.null_tag;
                d_blob_len = i_cfg.null_tag;
            end else begin
                d_ok = 1'b0;
            end
        end else begin
            d_ok = 1'b0;
        end
    end

    // message counter: reload on init, then count and check the limit
    always_comb begin
        if (d_reload) begin
            d_base = (i_cfg.packet_limit != 16'd0) ? 16'd0 : h_n;
        end else begin
            d_base = r_msg_cnt;
        end
        d_cnt   = d_base + 16'd1;
        d_abort = (i_cfg.packet_limit != 16'd0) && (d_cnt > i_cfg.packet_limit);
    end

    // read pipeline and output slot
    assign slot_free = !r_out_valid || i_out_ready;
    assign s2_adv    = (r_state == ST_EMIT) && r_rd_vld && slot_free;
    assign issue     = (r_state == ST_EMIT) && !r_iss_done && (!r_rd_vld || slot_free);
    assign load_emit = s2_adv;
    assign load_verd = (r_state == ST_VERD) && slot_free;
    assign o_q_pop   = (load_emit && r_rd_k == K_LAST) || load_verd;

    assign rd_ofs    = (r_state == ST_HDR) ? r_k : src_ofs(r_k);
    assign o_rd_en   = (r_state == ST_HDR) || issue;
    assign o_rd_addr = {i_q_head.bank, PW'(rd_ofs)};
    assign hdr_idx   = 4'(r_rd_k - K_HDR_LO);

    // rewritten byte for the offset whose data is in the read register
    assign word_byte = r_rd_k[2:0];
    assign ov_byte   = i_q_head.outb[8*word_byte +: 8];

    always_comb begin
        emit_byte = i_rd_data;
        priority if (r_rd_k == K_LEN) begin
            emit_byte = d_len;
        end else if (r_rd_k == K_STATE) begin
            emit_byte = h_other;
        end else if (r_rd_k == K_OTHER) begin
            emit_byte = d_other;
        end else if (r_rd_k == K_CNT_LSB) begin
            emit_byte = r_msg_cnt[7:0];
        end else if (r_rd_k == K_CNT_MSB) begin
            emit_byte = r_msg_cnt[15:8];
        end else if (r_rd_k == K_BLOB) begin
            emit_byte = d_blob;
        end else if (r_rd_k == K_BLOB_LEN) begin
            emit_byte = d_blob_len;
        end else if (r_rd_k >= K_WORD_I && r_rd_k < K_WORD_U) begin
            unique case (d_wi)
                WI_ONES: emit_byte = 8'hff;
                WI_OUTB: emit_byte = ov_byte;
                default: emit_byte = i_rd_data;
            endcase
        end else if (r_rd_k >= K_WORD_U && r_rd_k < K_MSG_END) begin
            emit_byte = (d_wu == WU_STORE) ? i_rd_data : 8'hff;
        end else begin
            emit_byte = i_rd_data;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_rd_k      = r_rd_k;
        n_rd_vld    = r_rd_vld;
        n_iss_done  = r_iss_done;
        n_msg_cnt   = r_msg_cnt;
        n_verdict   = r_verdict;
        n_taken     = r_taken;
        n_out_valid = r_out_valid;
        if (load_emit || load_verd) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                n_rd_vld = 1'b0;
                if (!i_q_empty) begin
                    if (i_q_head.short_frame) begin
                        n_verdict = VERD_DROP;
                        n_taken   = 1'b0;
                        n_state   = ST_VERD;
                    end else begin
                        n_k     = K_HDR_LO;
                        n_state = ST_HDR;
                    end
                end
            end
            ST_HDR: begin
                n_rd_vld = 1'b1;
                n_rd_k   = r_k;
                n_k      = r_k + 1'b1;
                if (r_k == K_BLOB_LEN) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_rd_vld = 1'b0;
                n_state  = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!d_ok) begin
                    n_verdict = VERD_DROP;
                    n_taken   = 1'b0;
                    n_state   = ST_VERD;
                end else begin
                    n_msg_cnt = d_cnt;
                    n_taken   = d_taken;
                    if (d_abort) begin
                        n_verdict = VERD_ABORT;
                        n_state   = ST_VERD;
                    end else begin
                        n_verdict  = VERD_XMIT;
                        n_k        = '0;
                        n_iss_done = 1'b0;
                        n_state    = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (issue) begin
                    n_rd_vld = 1'b1;
                    n_rd_k   = r_k;
                    n_k      = r_k + 1'b1;
                    if (r_k == K_LAST) begin
                        n_iss_done = 1'b1;
                    end
                end else if (s2_adv) begin
                    n_rd_vld = 1'b0;
                end
                if (s2_adv && r_rd_k == K_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_VERD: begin
                if (load_verd) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_rd_k      <= '0;
            r_rd_vld    <= 1'b0;
            r_iss_done  <= 1'b0;
            r_msg_cnt   <= 16'd0;
            r_verdict   <= VERD_DROP;
            r_taken     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_rd_k      <= n_rd_k;
            r_rd_vld    <= n_rd_vld;
            r_iss_done  <= n_iss_done;
            r_msg_cnt   <= n_msg_cnt;
            r_verdict   <= n_verdict;
            r_taken     <= n_taken;
            r_out_valid <= n_out_valid;
        end
    end

    // header capture
    always_ff @(posedge i_clk) begin
        if (r_rd_vld && (r_state == ST_HDR || r_state == ST_WAIT)) begin
            r_hdr[hdr_idx] <= i_rd_data;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load_emit) begin
            o_out_byte       <= emit_byte;
            o_out_last       <= r_rd_k == K_LAST;
            o_verdict        <= VERD_XMIT;
            o_outbound_taken <= r_taken;
        end else if (load_verd) begin
            o_out_byte       <= 8'd0;
            o_out_last       <= 1'b1;
            o_verdict        <= r_verdict;
            o_outbound_taken <= r_taken;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/ait_frame_responder.sv =====
// ----------------------------------------------------------------------------
// ait_frame_responder: frame responder for the two-party transfer handshake
// Collects a received frame, runs one handshake step and returns the
// rewritten frame with its verdict, or a single drop/abort beat.
//
//   channel  | handshake                  | beat
//   ---------+----------------------------+------------------------------------
//   input    | i_in_valid / o_in_ready    | frame byte, last flag, outbound word
//   result   | o_out_valid / i_out_ready  | byte, last flag, verdict, taken flag
//   config   | i_cfg_we                   | register index, data (16 bits)
//
// Input takes one byte per cycle while one of the two frame banks is free.
// Per frame the back end reads the header bytes from the single frame memory
// read port, runs the step and streams the rewritten frame; a short frame
// gives its drop beat. Reset clears control state, the message counter
// and the registers to their defaults; the frame memory is not cleared. A
// stalled result side stalls the back end only; input stalls once both banks
// hold frames.
// ----------------------------------------------------------------------------
module ait_frame_responder #(
    parameter int FRAME_BYTES = 64,
    parameter int MIN_FRAME   = 60
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_frame_byte,
    input  logic                           i_frame_last,
    input  logic                           i_outbound_present,
    input  logic [63:0]                    i_outbound_value,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_out_byte,
    output logic                           o_out_last,
    output logic [1:0]                     o_verdict,
    output logic                           o_outbound_taken,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [afr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [afr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import afr_pkg::*;

    localparam int PW = $clog2(FRAME_BYTES);
    localparam int AW = PW + 1;

    t_cfg        r_cfg, n_cfg;
    logic        q_push, q_pop, q_full, q_empty;
    t_frame_desc q_desc, q_head;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    // configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ETHERTYPE:    n_cfg.ethertype    = i_cfg_data;
                CFG_PACKET_LIMIT: n_cfg.packet_limit = i_cfg_data;
                CFG_ARRAY_TAG:    n_cfg.array_tag    = i_cfg_data[7:0];
                CFG_POSINT_TAG:   n_cfg.posint_tag   = i_cfg_data[7:0];
                CFG_OCTETS_TAG:   n_cfg.octets_tag   = i_cfg_data[7:0];
                CFG_NULL_TAG:     n_cfg.null_tag     = i_cfg_data[7:0];
                CFG_SMALL_ZERO:   n_cfg.small_zero   = i_cfg_data[7:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ethertype    <= RST_ETHERTYPE;
            r_cfg.packet_limit <= RST_PACKET_LIMIT;
            r_cfg.array_tag    <= RST_ARRAY_TAG;
            r_cfg.posint_tag   <= RST_POSINT_TAG;
            r_cfg.octets_tag   <= RST_OCTETS_TAG;
            r_cfg.null_tag     <= RST_NULL_TAG;
            r_cfg.small_zero   <= RST_SMALL_ZERO;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // receive side
    afr_front #(
        .FRAME_BYTES (FRAME_BYTES),
        .MIN_FRAME   (MIN_FRAME)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_frame_byte       (i_frame_byte),
        .i_frame_last       (i_frame_last),
        .i_outbound_present (i_outbound_present),
        .i_outbound_value   (i_outbound_value),
        .i_q_full           (q_full),
        .o_q_push           (q_push),
        .o_q_desc           (q_desc),
        .o_wr_en            (ram_we),
        .o_wr_addr          (ram_waddr),
        .o_wr_data          (ram_wdata)
    );

    // two-bank frame memory
    afr_frame_ram #(
        .AW (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // frames waiting for the back end
    afr_desc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_desc),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // handshake step and transmit
    afr_back #(
        .FRAME_BYTES (FRAME_BYTES),
        .MIN_FRAME   (MIN_FRAME)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_empty        (q_empty),
        .i_q_head         (q_head),
        .o_q_pop          (q_pop),
        .o_rd_en          (ram_re),
        .o_rd_addr        (ram_raddr),
        .i_rd_data        (ram_rdata),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_out_last       (o_out_last),
        .o_verdict        (o_verdict),
        .o_outbound_taken (o_outbound_taken)
    );

`ifndef ASSERT_OFF
    // a frame is queued only when a bank is free
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("descriptor pushed into a full queue");

    // the back end retires only frames that were queued
    a_pop_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("descriptor popped from an empty queue");

    // drop and abort are single zero beats
    a_short_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict != VERD_XMIT) |-> (o_out_last && o_out_byte == 8'd0))
        else $error("drop or abort beat is not a single zero byte");

    // a retired frame leaves its last beat in the output register
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_out_valid && o_out_last))
        else $error("frame retired without its last beat");
`endif

endmodule
